>>> src/watermark_inner_code_modulator_unit_assert.svh
// assertion macros for the watermark inner code modulator
`ifndef WATERMARK_INNER_CODE_MODULATOR_UNIT_ASSERT_SVH
`define WATERMARK_INNER_CODE_MODULATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define WICM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("wicm: assertion failed");

// next-cycle implication, disabled while in reset
`define WICM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wicm: assertion failed");

`endif

>>> src/wicm_pkg.sv
// shared types, field widths and codes of the watermark inner code modulator
`default_nettype none

package wicm_pkg;

    localparam int DEF_MAX_WORD_BITS   = 16;
    localparam int DEF_MAX_SYMBOL_BITS = 4;
    localparam int DEF_MAX_CODEBOOKS   = 4;
    localparam int DEF_MAX_VECTORS     = 16;

    localparam int ACTION_W = 2;
    localparam int TABLE_W  = 2;
    localparam int SLOT_W   = 4;
    localparam int ENTRY_W  = 16;

    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [ACTION_W-1:0] ACT_CODEWORD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_VECTOR   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ENCODE   = 2'd2;

    localparam logic [1:0] MODE_ZERO   = 2'd0;
    localparam logic [1:0] MODE_ALT    = 2'd1;
    localparam logic [1:0] MODE_VECTOR = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_WORD_BITS      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_BITS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CODEBOOK_COUNT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MARKER_MODE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_VECTOR_COUNT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LENGTH   = 3'd5;

    typedef struct packed {
        logic [4:0]  word_bits;
        logic [2:0]  symbol_bits;
        logic [2:0]  codebook_count;
        logic [1:0]  marker_mode;
        logic [4:0]  vector_count;
        logic [15:0] frame_length;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        word_bits:      5'd8,
        symbol_bits:    3'd4,
        codebook_count: 3'd1,
        marker_mode:    MODE_ZERO,
        vector_count:   5'd1,
        frame_length:   16'd1
    };

    // action sits in the lowest bits of the input word
    typedef struct packed {
        logic [ENTRY_W-1:0]  entry_word;
        logic [SLOT_W-1:0]   slot;
        logic [TABLE_W-1:0]  table_number;
        logic [ACTION_W-1:0] action;
    } in_t;

endpackage

`default_nettype wire

>>> src/wicm_lookup.sv
// position counters, codebook and vector memories, marker combine
`default_nettype none

module wicm_lookup #(
    parameter int MAX_WORD_BITS   = 16,
    parameter int MAX_SYMBOL_BITS = 4,
    parameter int MAX_CODEBOOKS   = 4,
    parameter int MAX_VECTORS     = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire wicm_pkg::cfg_t                      cfg,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire wicm_pkg::in_t                       in_item,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [MAX_WORD_BITS-1:0]                 out_word,
    output logic [$clog2(MAX_WORD_BITS+1)-1:0]       out_nbits
);
    import wicm_pkg::*;

    localparam int CB_DEPTH = MAX_CODEBOOKS << MAX_SYMBOL_BITS;
    localparam int CB_AW    = $clog2(CB_DEPTH);
    localparam int VEC_AW   = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int CPH_W    = (MAX_CODEBOOKS > 1) ? $clog2(MAX_CODEBOOKS) : 1;
    localparam int CBN_W    = $clog2(MAX_CODEBOOKS + 1);
    localparam int VN_W     = $clog2(MAX_VECTORS + 1);
    localparam int K_W      = $clog2(MAX_SYMBOL_BITS + 1);
    localparam int WB_W     = $clog2(MAX_WORD_BITS + 1);

    logic [MAX_WORD_BITS-1:0] cb_mem  [CB_DEPTH];
    logic [MAX_WORD_BITS-1:0] vec_mem [MAX_VECTORS];

    logic [MAX_WORD_BITS-1:0] cb_rd_reg, vec_rd_reg;
    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_odd_reg, s1_odd_next;
    logic [15:0]              pos_reg, pos_next;
    logic [CPH_W-1:0]         cph_reg, cph_next;
    logic [VEC_AW-1:0]        vph_reg, vph_next;

    logic [WB_W-1:0]          n;
    logic [K_W-1:0]           k;
    logic [CBN_W-1:0]         cbn;
    logic [VN_W-1:0]          vn;
    logic [15:0]              flen;
    logic                     stale;
    logic [15:0]              pos_eff;
    logic [CPH_W-1:0]         cph_eff;
    logic [VEC_AW-1:0]        vph_eff;
    logic                     frame_end;
    logic [SLOT_W-1:0]        sym_mask, sym;
    logic                     accept, rd_en, cb_we, vec_we;
    logic [CB_AW-1:0]         cb_raddr, cb_waddr;
    logic [VEC_AW-1:0]        vec_waddr;
    logic [MAX_WORD_BITS-1:0] wr_data;
    logic [MAX_WORD_BITS-1:0] nmask, marker;

    // saturate registers into their legal ranges
    always_comb begin
        if (cfg.word_bits == '0) begin
            n = WB_W'(1);
        end else if (int'(cfg.word_bits) > MAX_WORD_BITS) begin
            n = WB_W'(MAX_WORD_BITS);
        end else begin
            n = WB_W'(cfg.word_bits);
        end
        if (cfg.symbol_bits == '0) begin
            k = K_W'(1);
        end else if (int'(cfg.symbol_bits) > MAX_SYMBOL_BITS) begin
            k = K_W'(MAX_SYMBOL_BITS);
        end else begin
            k = K_W'(cfg.symbol_bits);
        end
        if (cfg.codebook_count == '0) begin
            cbn = CBN_W'(1);
        end else if (int'(cfg.codebook_count) > MAX_CODEBOOKS) begin
            cbn = CBN_W'(MAX_CODEBOOKS);
        end else begin
            cbn = CBN_W'(cfg.codebook_count);
        end
        if (cfg.vector_count == '0) begin
            vn = VN_W'(1);
        end else if (int'(cfg.vector_count) > MAX_VECTORS) begin
            vn = VN_W'(MAX_VECTORS);
        end else begin
            vn = VN_W'(cfg.vector_count);
        end
        flen = (cfg.frame_length == '0) ? 16'd1 : cfg.frame_length;
    end

    // stale counters fall back to the start of a frame
    always_comb begin
        stale   = (pos_reg >= flen);
        pos_eff = stale ? '0 : pos_reg;
        cph_eff = (stale || int'(cph_reg) >= int'(cbn)) ? '0 : cph_reg;
        vph_eff = (stale || int'(vph_reg) >= int'(vn)) ? '0 : vph_reg;
        frame_end = ({1'b0, pos_eff} + 17'd1) >= {1'b0, flen};
    end

    always_comb begin
        for (int i = 0; i < SLOT_W; i++) begin
            sym_mask[i] = (i < int'(k));
        end
        sym = in_item.slot & sym_mask;
        for (int i = 0; i < MAX_WORD_BITS; i++) begin
            nmask[i] = (i < int'(n));
        end
    end

    assign in_ready = !s1_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign rd_en    = accept && (in_item.action == ACT_ENCODE);
    assign cb_we    = accept && (in_item.action == ACT_CODEWORD)
                      && (int'(in_item.table_number) < MAX_CODEBOOKS)
                      && (int'(in_item.slot) < (1 << MAX_SYMBOL_BITS));
    assign vec_we   = accept && (in_item.action == ACT_VECTOR)
                      && (int'(in_item.slot) < MAX_VECTORS);
    assign cb_raddr  = CB_AW'((32'(cph_eff) << MAX_SYMBOL_BITS) | 32'(sym));
    assign cb_waddr  = CB_AW'((32'(in_item.table_number) << MAX_SYMBOL_BITS)
                              | 32'(in_item.slot));
    assign vec_waddr = VEC_AW'(in_item.slot);
    assign wr_data   = MAX_WORD_BITS'(in_item.entry_word);

    // at most one item per cycle (none while in_ready is low), so a write and a read never
    // share an edge; a read at a later edge already sees the new entry
    always_ff @(posedge aclk) begin
        if (cb_we) begin
            cb_mem[cb_waddr] <= wr_data;
        end
        if (rd_en) begin
            cb_rd_reg <= cb_mem[cb_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (vec_we) begin
            vec_mem[vec_waddr] <= wr_data;
        end
        if (rd_en) begin
            vec_rd_reg <= vec_mem[vph_eff];
        end
    end

    always_comb begin
        pos_next      = pos_reg;
        cph_next      = cph_reg;
        vph_next      = vph_reg;
        s1_valid_next = s1_valid_reg;
        s1_odd_next   = s1_odd_reg;
        if (in_ready) begin
            s1_valid_next = rd_en;
        end
        if (rd_en) begin
            s1_odd_next = pos_eff[0];
            if (frame_end) begin
                pos_next = '0;
                cph_next = '0;
                vph_next = '0;
            end else begin
                pos_next = pos_eff + 16'd1;
                cph_next = (int'(cph_eff) + 1 >= int'(cbn)) ? '0 : cph_eff + 1'b1;
                vph_next = (int'(vph_eff) + 1 >= int'(vn)) ? '0 : vph_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            cph_reg      <= '0;
            vph_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            cph_reg      <= cph_next;
            vph_reg      <= vph_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_odd_reg <= s1_odd_next;
    end

    always_comb begin
        case (cfg.marker_mode)
            MODE_ALT:    marker = s1_odd_reg ? nmask : '0;
            MODE_VECTOR: marker = vec_rd_reg;
            default:     marker = '0;
        endcase
    end

    assign out_valid = s1_valid_reg;
    assign out_word  = (cb_rd_reg ^ marker) & nmask;
    assign out_nbits = n;

endmodule

`default_nettype wire

>>> src/wicm_serializer.sv
// word to serial bit shifter with last-bit flag
`default_nettype none

module wicm_serializer #(
    parameter int MAX_WORD_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [MAX_WORD_BITS-1:0]          in_word,
    input  wire logic [$clog2(MAX_WORD_BITS+1)-1:0] in_nbits,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   out_bit,
    output logic                                   out_last
);
    localparam int WB_W = $clog2(MAX_WORD_BITS + 1);

    logic                     valid_reg, valid_next;
    logic [MAX_WORD_BITS-1:0] shift_reg, shift_next;
    logic [WB_W-1:0]          left_reg, left_next;
    logic                     final_bit;

    assign final_bit = (left_reg == WB_W'(1));
    assign in_ready  = !valid_reg || (out_ready && final_bit);

    always_comb begin
        valid_next = valid_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
            shift_next = in_word;
            left_next  = in_nbits;
        end else if (valid_reg && out_ready) begin
            if (final_bit) begin
                valid_next = 1'b0;
            end else begin
                shift_next = shift_reg >> 1;
                left_next  = left_reg - WB_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

    assign out_valid = valid_reg;
    assign out_bit   = shift_reg[0];
    assign out_last  = final_bit;

endmodule

`default_nettype wire

>>> src/watermark_inner_code_modulator_unit.sv
// top level of the watermark inner code modulator
//
//   port group   dir   contents
//   s_*          in    load/encode words: action, table_number, slot, entry_word
//   m_*          out   transmitted bits: tx_bit in m_tdata, last_bit as m_tlast
//   cfg_*        in    register writes, no read-back
//
// a load word writes one memory entry
// an encode word is read from memory at the edge that takes it into the lookup stage,
// moves on into the serial shifter, then word_bits bits leave one per cycle while
// m_tready is high, so the serial shifter sets the rate
// the next word is taken while the previous one is still being shifted out
// reset is synchronous, active low; memories are not cleared
// a stall on m_tready holds the shifter and then the lookup stage behind it
`default_nettype none

module watermark_inner_code_modulator_unit #(
    parameter int MAX_WORD_BITS   = wicm_pkg::DEF_MAX_WORD_BITS,
    parameter int MAX_SYMBOL_BITS = wicm_pkg::DEF_MAX_SYMBOL_BITS,
    parameter int MAX_CODEBOOKS   = wicm_pkg::DEF_MAX_CODEBOOKS,
    parameter int MAX_VECTORS     = wicm_pkg::DEF_MAX_VECTORS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // action[1:0], table_number[3:2], slot[7:4], entry_word[23:8]
    input  wire logic [wicm_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // tx_bit[0], zero fill above
    output logic [wicm_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                    m_tlast,
    input  wire logic                               cfg_wr_en,
    input  wire logic [wicm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [wicm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import wicm_pkg::*;

    localparam int WB_W = $clog2(MAX_WORD_BITS + 1);

    cfg_t                     cfg_reg, cfg_next;
    in_t                      in_item;
    logic                     lk_valid, lk_ready;
    logic [MAX_WORD_BITS-1:0] lk_word;
    logic [WB_W-1:0]          lk_nbits;
    logic                     ser_bit;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_WORD_BITS:      cfg_next.word_bits      = cfg_data[4:0];
                REG_SYMBOL_BITS:    cfg_next.symbol_bits    = cfg_data[2:0];
                REG_CODEBOOK_COUNT: cfg_next.codebook_count = cfg_data[2:0];
                REG_MARKER_MODE:    cfg_next.marker_mode    = cfg_data[1:0];
                REG_VECTOR_COUNT:   cfg_next.vector_count   = cfg_data[4:0];
                REG_FRAME_LENGTH:   cfg_next.frame_length   = cfg_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_item = in_t'(s_tdata);

    wicm_lookup #(
        .MAX_WORD_BITS   (MAX_WORD_BITS),
        .MAX_SYMBOL_BITS (MAX_SYMBOL_BITS),
        .MAX_CODEBOOKS   (MAX_CODEBOOKS),
        .MAX_VECTORS     (MAX_VECTORS)
    ) u_lookup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (lk_valid),
        .out_ready (lk_ready),
        .out_word  (lk_word),
        .out_nbits (lk_nbits)
    );

    wicm_serializer #(
        .MAX_WORD_BITS (MAX_WORD_BITS)
    ) u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lk_valid),
        .in_ready  (lk_ready),
        .in_word   (lk_word),
        .in_nbits  (lk_nbits),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_bit   (ser_bit),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, ser_bit};

`include "watermark_inner_code_modulator_unit_assert.svh"

    // input only backs up behind a word waiting in the lookup stage
    `WICM_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_tready, lk_valid)
    // an accepted encode word is in the lookup stage in the next cycle
    `WICM_ASSERT_NEXT(a_encode_lookup, aclk, aresetn,
        s_tvalid && s_tready && in_item.action == ACT_ENCODE, lk_valid)
    // a symbol's bits come without gaps until its last bit
    `WICM_ASSERT_NEXT(a_word_unbroken, aclk, aresetn,
        m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

`default_nettype wire

>>> tb/watermark_inner_code_modulator_unit_tb.sv
// self-checking testbench for the watermark inner code modulator: loads, encodes, stalls, limits
module watermark_inner_code_modulator_unit_tb;
    import wicm_pkg::*;

    localparam int CB_ENTRIES      = DEF_MAX_CODEBOOKS << DEF_MAX_SYMBOL_BITS;
    localparam int NUM_VECTORS     = DEF_MAX_VECTORS;
    localparam int IDLE_MAX        = 13;
    localparam int DRAIN_CYCLES    = 24;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_ROUNDS   = 10;
    localparam int ITEMS_PER_ROUND = 32;
    localparam int LONG_HOLD       = 300;

    // the one action code the block drops
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic tx_bit;
        logic last_bit;
    } line_bit_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // mirror of the block's registers, stores and frame counters
    cfg_t        regs;
    logic [15:0] codebook_mem [CB_ENTRIES];
    logic [15:0] vector_mem [NUM_VECTORS];
    bit          cb_loaded [CB_ENTRIES];
    bit          vec_loaded [NUM_VECTORS];
    int          frame_pos;
    int          cb_phase;
    int          vec_phase;

    line_bit_t   expected_bits [$];

    bit          send_gaps_on;
    bit          recv_gaps_on;
    int          hold_off_cycles;
    int          error_count;
    int          cycle_count;

    watermark_inner_code_modulator_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // position and phases as the next encode sees them
    function automatic void frame_view(output int pos, output int cph, output int vph);
        int cbn, vn, flen;
        cbn  = clamp_int(regs.codebook_count, 1, DEF_MAX_CODEBOOKS);
        vn   = clamp_int(regs.vector_count, 1, DEF_MAX_VECTORS);
        flen = clamp_int(regs.frame_length, 1, 65535);
        pos  = frame_pos;
        cph  = cb_phase;
        vph  = vec_phase;
        if (pos >= flen) begin
            pos = 0;
            cph = 0;
            vph = 0;
        end
        if (cph >= cbn) cph = 0;
        if (vph >= vn) vph = 0;
    endfunction

    function automatic int codeword_index(logic [3:0] slot);
        int pos, cph, vph, k;
        frame_view(pos, cph, vph);
        k = clamp_int(regs.symbol_bits, 1, DEF_MAX_SYMBOL_BITS);
        return (cph << DEF_MAX_SYMBOL_BITS) + (int'(slot) & ((1 << k) - 1));
    endfunction

    function automatic int vector_index();
        int pos, cph, vph;
        frame_view(pos, cph, vph);
        return vph;
    endfunction

    function automatic void clear_model();
        regs      = CFG_RESET;
        frame_pos = 0;
        cb_phase  = 0;
        vec_phase = 0;
        for (int i = 0; i < CB_ENTRIES; i++) cb_loaded[i] = 1'b0;
        for (int i = 0; i < NUM_VECTORS; i++) vec_loaded[i] = 1'b0;
    endfunction

    // applies one accepted word and queues the line bits it produces
    function automatic void modulate_word(in_t w);
        int          n, pos, cph, vph, cbn, vn, flen;
        logic [15:0] word_mask, marker, line_word;
        case (w.action)
            ACT_CODEWORD: begin
                codebook_mem[{w.table_number, w.slot}] = w.entry_word;
                cb_loaded[{w.table_number, w.slot}]    = 1'b1;
            end
            ACT_VECTOR: begin
                vector_mem[w.slot] = w.entry_word;
                vec_loaded[w.slot] = 1'b1;
            end
            ACT_ENCODE: begin
                n    = clamp_int(regs.word_bits, 1, DEF_MAX_WORD_BITS);
                cbn  = clamp_int(regs.codebook_count, 1, DEF_MAX_CODEBOOKS);
                vn   = clamp_int(regs.vector_count, 1, DEF_MAX_VECTORS);
                flen = clamp_int(regs.frame_length, 1, 65535);
                frame_view(pos, cph, vph);
                word_mask = 16'hFFFF >> (16 - n);
                if (regs.marker_mode == MODE_ALT)
                    marker = pos[0] ? word_mask : 16'h0000;
                else if (regs.marker_mode == MODE_VECTOR)
                    marker = vector_mem[vph];
                else
                    marker = 16'h0000;
                line_word = (codebook_mem[codeword_index(w.slot)] ^ marker) & word_mask;
                for (int j = 0; j < n; j++)
                    expected_bits.push_back('{tx_bit: line_word[j], last_bit: (j == n - 1)});
                if (pos + 1 >= flen) begin
                    frame_pos = 0;
                    cb_phase  = 0;
                    vec_phase = 0;
                end else begin
                    frame_pos = pos + 1;
                    cb_phase  = (cph + 1 >= cbn) ? 0 : cph + 1;
                    vec_phase = (vph + 1 >= vn) ? 0 : vph + 1;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(in_t w);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, IDLE_MAX) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        modulate_word(w);
    endtask

    task automatic load_codeword(logic [1:0] tbl, logic [3:0] slot, logic [15:0] entry);
        in_t w;
        w.action       = ACT_CODEWORD;
        w.table_number = tbl;
        w.slot         = slot;
        w.entry_word   = entry;
        send_word(w);
    endtask

    task automatic load_vector(logic [3:0] idx, logic [15:0] entry);
        in_t w;
        w.action       = ACT_VECTOR;
        w.table_number = 2'($urandom);
        w.slot         = idx;
        w.entry_word   = entry;
        send_word(w);
    endtask

    // fills any entry the encode would read before sending it
    task automatic encode_symbol(logic [3:0] slot);
        in_t w;
        int  idx;
        idx = codeword_index(slot);
        if (!cb_loaded[idx])
            load_codeword(idx[5:4], idx[3:0], 16'($urandom));
        if (regs.marker_mode == MODE_VECTOR && !vec_loaded[vector_index()])
            load_vector(4'(vector_index()), 16'($urandom));
        w.action       = ACT_ENCODE;
        w.table_number = 2'($urandom);
        w.slot         = slot;
        w.entry_word   = 16'($urandom);
        send_word(w);
    endtask

    task automatic send_unused();
        in_t w;
        w            = in_t'(S_TDATA_W'($urandom));
        w.action     = ACT_UNUSED;
        send_word(w);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_bits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_WORD_BITS:      regs.word_bits      = value[4:0];
            REG_SYMBOL_BITS:    regs.symbol_bits    = value[2:0];
            REG_CODEBOOK_COUNT: regs.codebook_count = value[2:0];
            REG_MARKER_MODE:    regs.marker_mode    = value[1:0];
            REG_VECTOR_COUNT:   regs.vector_count   = value[4:0];
            REG_FRAME_LENGTH:   regs.frame_length   = value;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] wb, logic [15:0] sb, logic [15:0] cc,
                              logic [15:0] mm, logic [15:0] vc, logic [15:0] fl);
        write_reg(REG_WORD_BITS, wb);
        write_reg(REG_SYMBOL_BITS, sb);
        write_reg(REG_CODEBOOK_COUNT, cc);
        write_reg(REG_MARKER_MODE, mm);
        write_reg(REG_VECTOR_COUNT, vc);
        write_reg(REG_FRAME_LENGTH, fl);
    endtask

    task automatic test_reset_defaults();
        load_codeword(2'd0, 4'd0, 16'hFFFF);
        load_codeword(2'd0, 4'd15, 16'h0000);
        load_codeword(2'd3, 4'd15, 16'hFFFF);
        encode_symbol(4'd0);
        encode_symbol(4'd15);
        send_unused();
        encode_symbol(4'd0);
        wait_idle();
    endtask

    // zero saturates up, all-ones saturates down, marker mode three acts as zero
    task automatic test_register_limits();
        set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        encode_symbol(4'hF);
        encode_symbol(4'h2);
        wait_idle();
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        encode_symbol(4'hF);
        encode_symbol(4'h0);
        wait_idle();
    endtask

    // short word masks the stored codewords, frame wraps after three symbols
    task automatic test_alternating_marker();
        set_config(16'd5, 16'd2, 16'd3, 16'(MODE_ALT), 16'd1, 16'd3);
        encode_symbol(4'hC);
        encode_symbol(4'h3);
        encode_symbol(4'h1);
        encode_symbol(4'hC);
        wait_idle();
    endtask

    task automatic test_vector_marker();
        set_config(16'd9, 16'd4, 16'd1, 16'(MODE_VECTOR), 16'd3, 16'd4);
        load_vector(4'd15, 16'hFFFF);
        load_vector(4'd0, 16'h0000);
        encode_symbol(4'd0);
        encode_symbol(4'd15);
        encode_symbol(4'd0);
        encode_symbol(4'd15);
        wait_idle();
    endtask

    // shrink the frame and the vector count under live counters
    task automatic test_stale_counters();
        encode_symbol(4'd0);
        encode_symbol(4'd15);
        wait_idle();
        write_reg(REG_FRAME_LENGTH, 16'd2);
        encode_symbol(4'd0);
        wait_idle();
        write_reg(REG_VECTOR_COUNT, 16'd1);
        encode_symbol(4'd15);
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_config(16'd16, 16'd4, 16'd2, 16'(MODE_ALT), 16'd1, 16'd7);
        send_gaps_on    = 1'b0;
        hold_off_cycles = LONG_HOLD;
        for (int i = 0; i < 24; i++) encode_symbol(4'($urandom));
        wait_idle();
        send_gaps_on = 1'b1;
    endtask

    // round 0 takes the top of each range, round 1 the bottom, then mostly in range
    function automatic logic [15:0] pick_reg(int round, int lo, int hi);
        if (round == 0) return 16'(hi);
        if (round == 1) return 16'(lo);
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'($urandom_range(lo, hi));
    endfunction

    task automatic test_random_traffic();
        int          sent, pick;
        logic [15:0] fl, mm;
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            fl = pick_reg(round, 1, 20);
            if (round == 1 || $urandom_range(0, 5) == 0) fl = 16'hFFFF;
            mm = (round == 0) ? 16'(MODE_VECTOR) : 16'($urandom_range(0, 3));
            set_config(pick_reg(round, 1, 16), pick_reg(round, 1, 4), pick_reg(round, 1, 4),
                       mm, pick_reg(round, 1, 16), fl);
            sent = 0;
            while (sent < ITEMS_PER_ROUND) begin
                if (sent % 12 == 0) begin
                    send_gaps_on = ($urandom_range(0, 3) != 0);
                    recv_gaps_on = ($urandom_range(0, 3) != 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 68) begin
                    encode_symbol(4'($urandom));
                    sent++;
                end else if (pick < 82) begin
                    load_codeword(2'($urandom), 4'($urandom), 16'($urandom));
                    sent++;
                end else if (pick < 94) begin
                    load_vector(4'($urandom), 16'($urandom));
                    sent++;
                end else begin
                    send_unused();
                end
            end
            wait_idle();
        end
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
    endtask

    // result side: random stall before each bit, plus any long hold asked for
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = recv_gaps_on ? $urandom_range(0, IDLE_MAX) : 0;
            gap = gap + hold_off_cycles;
            hold_off_cycles = 0;
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        line_bit_t exp_bit;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bits.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected word: tdata %h tlast %b", m_tdata, m_tlast);
            end else begin
                exp_bit = expected_bits.pop_front();
                if (m_tdata[0] !== exp_bit.tx_bit || m_tdata[M_TDATA_W-1:1] !== '0 ||
                    m_tlast !== exp_bit.last_bit) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("bit mismatch: expected tdata %h tlast %b, got tdata %h tlast %b",
                                 8'(exp_bit.tx_bit), exp_bit.last_bit, m_tdata, m_tlast);
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        send_gaps_on    = 1'b1;
        recv_gaps_on    = 1'b1;
        hold_off_cycles = 0;
        error_count     = 0;
        clear_model();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_register_limits();
        test_alternating_marker();
        test_vector_marker();
        test_stale_counters();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
